// ===== rtl/lhl_pkg.sv =====
// Package for the Lua highlight lexer: token classes, byte classes, word match tables.
// Used by every module of the lexer; no dependencies.
package lhl_pkg;

   localparam int MaxLineLenDefault = 4096;
   localparam int MaxWordLenDefault = 8;
   localparam int ColWidth = 12;
   localparam int LenWidth = 13;
   localparam int TableWordLen = 8;

   typedef enum logic [2:0] {
      CLS_DEFAULT  = 3'd0,
      CLS_KEYWORD  = 3'd1,
      CLS_BUILTIN  = 3'd2,
      CLS_STRING   = 3'd3,
      CLS_NUMBER   = 3'd4,
      CLS_COMMENT  = 3'd5,
      CLS_FUNCTION = 3'd6
   } token_class_type;

   // Right-justified word: last char in bits 7:0, zero padded above
   typedef logic [8*TableWordLen-1:0] word_type;

   // Token finished by the front end; word class is resolved in the back end
   typedef struct packed {
      logic            is_word;
      logic            paren_next;
      logic            too_long;
      logic [3:0]      fill;
      logic [8*TableWordLen-1:0] word;
      token_class_type cls;
      logic [ColWidth-1:0] start;
      logic [LenWidth-1:0] length;
      logic            last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   localparam int NumKw = 22;
   localparam int NumBi = 53;

   // Word bytes are never zero, so equal padded values mean equal words
   localparam logic [NumKw-1:0][8*TableWordLen-1:0] KwTable = {
      64'("and"), 64'("break"), 64'("do"), 64'("else"), 64'("elseif"), 64'("end"),
      64'("false"), 64'("for"), 64'("function"), 64'("goto"), 64'("if"), 64'("in"),
      64'("local"), 64'("nil"), 64'("not"), 64'("or"), 64'("repeat"), 64'("return"),
      64'("then"), 64'("true"), 64'("until"), 64'("while")
   };

   localparam logic [NumBi-1:0][8*TableWordLen-1:0] BiTable = {
      64'("_init"), 64'("_update"), 64'("_draw"), 64'("cls"), 64'("pset"),
      64'("pget"), 64'("line"), 64'("rect"), 64'("rectfill"), 64'("circ"),
      64'("circfill"), 64'("spr"), 64'("sspr"), 64'("print"), 64'("camera"),
      64'("clip"), 64'("pal"), 64'("map"), 64'("mget"), 64'("mset"), 64'("fget"),
      64'("mapload"), 64'("btn"), 64'("btnp"), 64'("sfx"), 64'("music"),
      64'("stop"), 64'("volume"), 64'("save"), 64'("load"), 64'("delete"),
      64'("flr"), 64'("ceil"), 64'("abs"), 64'("sgn"), 64'("min"), 64'("max"),
      64'("mid"), 64'("sin"), 64'("cos"), 64'("atan2"), 64'("sqrt"), 64'("rnd"),
      64'("irnd"), 64'("srand"), 64'("time"), 64'("dt"), 64'("fps"), 64'("stat"),
      64'("exit"), 64'("trace"), 64'("overlap"), 64'("distance")
   };

   function automatic logic is_keyword(input word_type w);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumKw; i++) hit |= (w == KwTable[i]);
      return hit;
   endfunction

   function automatic logic is_builtin(input word_type w);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumBi; i++) hit |= (w == BiTable[i]);
      return hit;
   endfunction

endpackage

// ===== rtl/lhl_front.sv =====
// Front end: per-byte lexer state machine, emits up to two raw tokens per transaction.
// Depends on lhl_pkg.
module lhl_front #(
   parameter int MAX_LINE_LEN = lhl_pkg::MaxLineLenDefault,
   parameter int MAX_WORD_LEN = lhl_pkg::MaxWordLenDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               kind,
   input  logic [7:0]         ch,
   output logic               tok_a_vld,
   output lhl_pkg::token_type tok_a,
   output logic               tok_b_vld,
   output lhl_pkg::token_type tok_b
);
   import lhl_pkg::*;

   localparam int WIdxW = $clog2(MAX_WORD_LEN);
   // Internal counters cover the full line length; tokens carry the low bits
   localparam int ColW = ($clog2(MAX_LINE_LEN) > ColWidth) ? $clog2(MAX_LINE_LEN)
                                                           : ColWidth;
   localparam int RunW = ($clog2(MAX_LINE_LEN + 1) > LenWidth) ? $clog2(MAX_LINE_LEN + 1)
                                                               : LenWidth;

   typedef enum logic [2:0] {
      M_IDLE, M_DASH, M_DOT, M_NUMBER, M_IDENT, M_STRING, M_COMMENT
   } mode_type;

   mode_type mode_ff, mode_in;
   logic quote_dq_ff, quote_dq_in;
   logic esc_ff, esc_in;
   logic [7:0] word_ff [MAX_WORD_LEN];
   logic [7:0] word_in [MAX_WORD_LEN];
   logic [4:0] fill_ff, fill_in;
   logic too_long_ff, too_long_in;
   logic [ColW-1:0] start_ff, start_in;
   logic [RunW-1:0] run_ff, run_in;
   logic [ColW-1:0] col_ff, col_in;

   logic [RunW-1:0] run_grow;
   logic [8*TableWordLen-1:0] word_flat;
   logic [3:0] fill_tab;
   logic open_byte;

   // Words longer than the table width never match, so only 8 bytes are compared
   always_comb begin
      word_flat = '0;
      for (int k = 0; k < TableWordLen; k++) begin
         if (k < MAX_WORD_LEN && 5'(k) < fill_ff) word_flat[8*k +: 8] = word_ff[k];
      end
      fill_tab = (fill_ff > 5'(TableWordLen)) ? 4'hf : fill_ff[3:0];
   end

   assign run_grow = (run_ff < RunW'(MAX_LINE_LEN)) ? run_ff + 1'b1 : run_ff;

   always_comb begin
      token_type t0;
      t0 = '0;
      t0.start = start_ff[ColWidth-1:0];
      t0.length = run_ff[LenWidth-1:0];
      t0.word = word_flat;
      t0.fill = fill_tab;
      t0.too_long = too_long_ff || (fill_ff > 5'(TableWordLen));

      mode_in = mode_ff;
      quote_dq_in = quote_dq_ff;
      esc_in = esc_ff;
      word_in = word_ff;
      fill_in = fill_ff;
      too_long_in = too_long_ff;
      start_in = start_ff;
      run_in = run_ff;
      col_in = col_ff;
      tok_a_vld = 1'b0;
      tok_a = t0;
      tok_b_vld = 1'b0;
      tok_b = t0;
      open_byte = 1'b0;

      if (kind) begin
         // End of line flushes whatever is pending
         case (mode_ff)
            M_DASH, M_DOT: begin
               tok_a_vld = 1'b1; tok_a.cls = CLS_DEFAULT; tok_a.length = LenWidth'(1);
            end
            M_NUMBER:  begin tok_a_vld = 1'b1; tok_a.cls = CLS_NUMBER; end
            M_IDENT:   begin tok_a_vld = 1'b1; tok_a.is_word = 1'b1; end
            M_STRING:  begin tok_a_vld = 1'b1; tok_a.cls = CLS_STRING; end
            M_COMMENT: begin tok_a_vld = 1'b1; tok_a.cls = CLS_COMMENT; end
            default: ;
         endcase
         mode_in = M_IDLE;
         esc_in = 1'b0;
         col_in = '0;
      end else begin
         case (mode_ff)
            M_DASH: begin
               if (ch == 8'h2d) begin mode_in = M_COMMENT; run_in = run_grow; end
               else begin
                  tok_a_vld = 1'b1; tok_a.cls = CLS_DEFAULT; tok_a.length = LenWidth'(1);
                  open_byte = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(ch)) begin mode_in = M_NUMBER; run_in = run_grow; end
               else begin
                  tok_a_vld = 1'b1; tok_a.cls = CLS_DEFAULT; tok_a.length = LenWidth'(1);
                  open_byte = 1'b1;
               end
            end
            M_NUMBER: begin
               if (is_digit(ch) || is_alpha(ch) || ch == 8'h2e) run_in = run_grow;
               else begin
                  tok_a_vld = 1'b1; tok_a.cls = CLS_NUMBER; open_byte = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_digit(ch) || is_alpha(ch) || ch == 8'h5f) begin
                  if (fill_ff < 5'(MAX_WORD_LEN)) begin
                     word_in[fill_ff[WIdxW-1:0]] = ch;
                     fill_in = fill_ff + 1'b1;
                  end else too_long_in = 1'b1;
                  run_in = run_grow;
               end else begin
                  tok_a_vld = 1'b1; tok_a.is_word = 1'b1;
                  tok_a.paren_next = (ch == 8'h28);
                  open_byte = 1'b1;
               end
            end
            M_STRING: begin
               run_in = run_grow;
               if (esc_ff) esc_in = 1'b0;
               else if (ch == 8'h5c) esc_in = 1'b1;
               else if (ch == (quote_dq_ff ? 8'h22 : 8'h27)) begin
                  tok_a_vld = 1'b1; tok_a.cls = CLS_STRING;
                  tok_a.length = run_grow[LenWidth-1:0];
                  mode_in = M_IDLE;
               end
            end
            M_COMMENT: run_in = run_grow;
            default: open_byte = 1'b1;
         endcase

         // Lex this byte from idle
         if (open_byte) begin
            start_in = col_ff;
            run_in = RunW'(1);
            if (ch == 8'h2d) mode_in = M_DASH;
            else if (ch == 8'h22 || ch == 8'h27) begin
               mode_in = M_STRING; quote_dq_in = (ch == 8'h22); esc_in = 1'b0;
            end else if (is_digit(ch)) mode_in = M_NUMBER;
            else if (ch == 8'h2e) mode_in = M_DOT;
            else if (is_alpha(ch) || ch == 8'h5f) begin
               mode_in = M_IDENT; word_in[0] = ch; fill_in = 5'd1; too_long_in = 1'b0;
            end else begin
               mode_in = M_IDLE;
               tok_b_vld = 1'b1;
               tok_b = '0;
               tok_b.cls = CLS_DEFAULT;
               tok_b.start = col_ff[ColWidth-1:0];
               tok_b.length = LenWidth'(1);
            end
         end
         if (col_ff < ColW'(MAX_LINE_LEN - 1)) col_in = col_ff + 1'b1;
      end
      tok_a.last = !tok_b_vld;
      tok_b.last = 1'b1;
   end

   // Lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         quote_dq_ff <= 1'b0;
         esc_ff <= 1'b0;
         fill_ff <= '0;
         too_long_ff <= 1'b0;
         start_ff <= '0;
         run_ff <= '0;
         col_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         quote_dq_ff <= quote_dq_in;
         esc_ff <= esc_in;
         fill_ff <= fill_in;
         too_long_ff <= too_long_in;
         start_ff <= start_in;
         run_ff <= run_in;
         col_ff <= col_in;
      end
   end

   // Word bytes: payload only
   always_ff @(posedge clock) begin
      if (take) word_ff <= word_in;
   end
endmodule

// ===== rtl/lhl_queue.sv =====
// Token queue between front and back end; accepts up to two entries per cycle.
// Depends on lhl_pkg.
module lhl_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_a,
   input  lhl_pkg::token_type data_a,
   input  logic               push_b,
   input  lhl_pkg::token_type data_b,
   input  logic               pop,
   output logic               not_empty,
   output logic               room_two,
   output lhl_pkg::token_type head
);
   import lhl_pkg::*;

   localparam int AW = $clog2(DEPTH);

   token_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] cnt_ff;
   logic [AW-1:0] wr_b;
   logic [1:0] n_push;

   assign not_empty = (cnt_ff != '0);
   assign room_two = (cnt_ff <= (AW+1)'(DEPTH - 2));
   assign head = mem_ff[rd_ff];
   assign wr_b = push_a ? wr_ff + 1'b1 : wr_ff;
   assign n_push = {1'b0, push_a} + {1'b0, push_b};

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff + AW'(n_push);
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(n_push) - (AW+1)'(pop);
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_a) mem_ff[wr_ff] <= data_a;
      if (push_b) mem_ff[wr_b] <= data_b;
   end
endmodule

// ===== rtl/lhl_back.sv =====
// Back end: resolves word class against the keyword/builtin tables, output register.
// Depends on lhl_pkg.
module lhl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_vld,
   input  lhl_pkg::token_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_token_class,
   output logic [11:0]        rsp_token_start,
   output logic [12:0]        rsp_token_length,
   output logic               rsp_last_of_run
);
   import lhl_pkg::*;

   logic vld_ff;
   logic [2:0] cls_ff, cls_in;
   logic [11:0] start_ff;
   logic [12:0] len_ff;
   logic last_ff;
   word_type word_rj;

   // Output register loads when empty or drained
   assign q_pop = q_vld && (!vld_ff || !rsp_stall);

   // Right-justify the stored word so it lines up with the table entries
   always_comb begin
      word_rj = '0;
      for (int k = 0; k < TableWordLen; k++) begin
         if (4'(k) < q_head.fill)
            word_rj = {word_rj[8*TableWordLen-9:0], q_head.word[8*k +: 8]};
      end
   end

   always_comb begin
      cls_in = q_head.cls;
      if (q_head.is_word) begin
         if (!q_head.too_long && is_keyword(word_rj)) cls_in = CLS_KEYWORD;
         else if (!q_head.too_long && is_builtin(word_rj))
            cls_in = CLS_BUILTIN;
         else if (q_head.paren_next) cls_in = CLS_FUNCTION;
         else cls_in = CLS_DEFAULT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (q_pop) vld_ff <= 1'b1;
      else if (!rsp_stall) vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cls_ff <= cls_in;
         start_ff <= q_head.start;
         len_ff <= q_head.length;
         last_ff <= q_head.last;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_token_class = cls_ff;
   assign rsp_token_start = start_ff;
   assign rsp_token_length = len_ff;
   assign rsp_last_of_run = last_ff;
endmodule

// ===== rtl/lua_highlight_token_lexer_core.sv =====
// Top level of the Lua highlight lexer: front end, token queue, back end.
// Depends on lhl_pkg, lhl_front, lhl_queue, lhl_back.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_kind, req_ch
//   rsp     | out       | rsp_valid, rsp_stall, rsp_token_class/start/length, rsp_last_of_run
//
// One transaction per cycle in; tokens leave one per cycle from the back end unless rsp_stall.
// A transaction yields zero to two tokens; sustained rate is one transaction per
// cycle unless output is stalled or many single-byte tokens fill the 4-entry queue.
// Each token is queued, then registered at the output. Synchronous reset clears all control.
// req_stall rises when the queue cannot take two more tokens.
module lua_highlight_token_lexer_core #(
   parameter int MAX_LINE_LEN = lhl_pkg::MaxLineLenDefault,
   parameter int MAX_WORD_LEN = lhl_pkg::MaxWordLenDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_class,
   output logic [11:0] rsp_token_start,
   output logic [12:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import lhl_pkg::*;

   logic take;
   logic a_vld, b_vld, q_ne, q_room, q_pop;
   token_type tok_a, tok_b, q_head;

   assign req_stall = !q_room;
   assign take = req_valid && !req_stall;

   lhl_front #(.MAX_LINE_LEN(MAX_LINE_LEN), .MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
      .clock, .reset, .take, .kind(req_kind), .ch(req_ch),
      .tok_a_vld(a_vld), .tok_a, .tok_b_vld(b_vld), .tok_b
   );

   lhl_queue #(.DEPTH(4)) u_queue (
      .clock, .reset,
      .push_a(take && a_vld), .data_a(tok_a),
      .push_b(take && b_vld), .data_b(tok_b),
      .pop(q_pop), .not_empty(q_ne), .room_two(q_room), .head(q_head)
   );

   lhl_back u_back (
      .clock, .reset, .q_vld(q_ne), .q_head, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_token_class, .rsp_token_start,
      .rsp_token_length, .rsp_last_of_run
   );

   // A result never shows a zero length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_length != '0) else $error("zero-length token");

   // Class stays within the defined codes
   a_cls_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_class != 3'd7) else $error("bad token class");

   // Queue never pops while empty
   a_pop_safe: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_ne) else $error("pop from empty queue");
endmodule
